// ----- rtl/i2cme_pkg.sv -----
// Shared types and constants of the I2C master byte engine.
`default_nettype none
package i2cme_pkg;

    localparam int TPP_W   = 16;
    localparam int PHASE_W = 5;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam logic [PHASE_W-1:0] LAST_PHASE_START = 5'd1;
    localparam logic [PHASE_W-1:0] LAST_PHASE_STOP  = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_PHASE_BYTE  = 5'd18;
    localparam logic [PHASE_W-1:0] PHASE_ACK_LOW    = 5'd16;
    localparam logic [PHASE_W-1:0] PHASE_ACK_HIGH   = 5'd17;

    localparam logic [7:0] BYTE_MSB = 8'h80;

    typedef struct packed {
        logic scl;
        logic sda;
        logic en;
    } drive_t;

    typedef struct packed {
        logic       ack;
        logic [7:0] read_byte;
        logic       done;
        logic       busy;
        drive_t     drive;
    } seq_res_t;

    // bit positions in m_tdata
    localparam int RES_BUSY = 3;
    localparam int RES_DONE = 4;

endpackage
`default_nettype wire

// ----- rtl/i2c_master_byte_engine.sv -----
// I2C master byte engine: one input transfer per bus tick, one result transfer each.
// Each result is registered from its input transfer and offered in the cycle after it is taken.
// Throughput: one transfer per cycle unless m_tready stalls; one-pass state update.
// s_tready follows the result register: high when it is empty or being drained.
// Reset (aresetn low, synchronous): idle, SCL/SDA high, SDA released, phase length 1.
`default_nettype none
module i2c_master_byte_engine
    import i2cme_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wen,
    input  wire logic [TPP_W-1:0] cfg_wdata,   // ticks_per_phase
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,     // [7:0] write_data, [8] sda_in, zero fill
    input  wire logic [2:0]       s_tuser,     // [2:0] func
    input  wire logic             s_tlast,     // last_read
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata      // [0] scl_level, [1] sda_level,
                                               // [2] sda_enable, [3] busy_res,
                                               // [4] done_res, [12:5] read_byte,
                                               // [13] ack_seen, zero fill
);

    logic [TPP_W-1:0] tpp_reg;
    logic             m_valid_reg;
    logic [15:0]      m_data_reg;
    logic             accept;
    seq_res_t         res;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpp_reg <= TPP_W'(1);
        end else if (cfg_wen) begin
            tpp_reg <= cfg_wdata;
        end
    end

    i2cme_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (accept),
        .func       (s_tuser),
        .write_data (s_tdata[7:0]),
        .last_read  (s_tlast),
        .sda_in     (s_tdata[8]),
        .tpp        (tpp_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {2'b00, res.ack, res.read_byte, res.done, res.busy,
                           res.drive.en, res.drive.sda, res.drive.scl};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[RES_DONE] |-> !m_data_reg[RES_BUSY])
        else $error("done result still reports busy");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted transfer produced no result");

endmodule
`default_nettype wire

// ----- rtl/i2cme_seq.sv -----
// Phase sequencer of the I2C master byte engine: state and per-tick update.
`default_nettype none
module i2cme_seq
    import i2cme_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic [2:0]       func,
    input  wire logic [7:0]       write_data,
    input  wire logic             last_read,
    input  wire logic             sda_in,
    input  wire logic [TPP_W-1:0] tpp,
    output seq_res_t              res
);

    cmd_t               cmd_reg, cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         shift_reg, shift_next;
    logic [TPP_W-1:0]   div_reg, div_next;
    drive_t             drive_reg, drive_next;
    logic               ack_reg, ack_next;
    logic               nack_reg, nack_next;
    logic [7:0]         read_reg, read_next;
    logic               done;
    logic [TPP_W-1:0]   div_dec;
    logic [TPP_W-1:0]   tpp_eff;
    logic [PHASE_W-1:0] last_phase;

    function automatic drive_t enter_drive(cmd_t c, logic [PHASE_W-1:0] p, logic bit7,
                                           logic nack, drive_t cur);
        drive_t d;
        d = cur;
        case (c)
            CMD_START: begin
                if (p == '0) begin
                    d = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
                end else begin
                    d.sda = 1'b0;
                end
            end
            CMD_STOP: begin
                if (p == '0) begin
                    d = '{scl: 1'b0, sda: 1'b0, en: 1'b1};
                end else if (p == 5'd1) begin
                    d.scl = 1'b1;
                end else begin
                    d.sda = 1'b1;
                end
            end
            CMD_WRITE, CMD_READ: begin
                if (p < PHASE_ACK_LOW) begin
                    if (!p[0]) begin
                        d.scl = 1'b0;
                        if (c == CMD_WRITE) begin
                            d.en  = 1'b1;
                            d.sda = bit7;
                        end else begin
                            d.en = 1'b0;
                        end
                    end else begin
                        d.scl = 1'b1;
                    end
                end else if (p == PHASE_ACK_LOW) begin
                    d.scl = 1'b0;
                    if (c == CMD_WRITE) begin
                        d.en = 1'b0;
                    end else begin
                        d.en  = 1'b1;
                        d.sda = nack;
                    end
                end else if (p == PHASE_ACK_HIGH) begin
                    d.scl = 1'b1;
                end else begin
                    d.scl = 1'b0;
                end
            end
            default: begin
                d = cur;
            end
        endcase
        return d;
    endfunction

    assign tpp_eff = (tpp == '0) ? TPP_W'(1) : tpp;
    assign div_dec = div_reg - TPP_W'(1);

    always_comb begin
        case (cmd_reg)
            CMD_START: last_phase = LAST_PHASE_START;
            CMD_STOP:  last_phase = LAST_PHASE_STOP;
            default:   last_phase = LAST_PHASE_BYTE;
        endcase
    end

    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        drive_next = drive_reg;
        ack_next   = ack_reg;
        nack_next  = nack_reg;
        read_next  = read_reg;
        done       = 1'b0;
        if (cmd_reg != CMD_IDLE) begin
            div_next = div_dec;
            if (div_dec == '0) begin
                if (phase_reg < PHASE_ACK_LOW && phase_reg[0]) begin
                    if (cmd_reg == CMD_WRITE) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                    end else if (cmd_reg == CMD_READ) begin
                        shift_next = {shift_reg[6:0], sda_in};
                        if (phase_reg == PHASE_ACK_LOW - 5'd1) begin
                            read_next = {shift_reg[6:0], sda_in};
                        end
                    end
                end else if (phase_reg == PHASE_ACK_HIGH && cmd_reg == CMD_WRITE) begin
                    ack_next = !sda_in;
                end
                if (phase_reg >= last_phase) begin
                    cmd_next   = CMD_IDLE;
                    phase_next = '0;
                    done       = 1'b1;
                end else begin
                    phase_next = phase_reg + 5'd1;
                    div_next   = tpp_eff;
                    drive_next = enter_drive(cmd_reg, phase_reg + 5'd1,
                                             |(shift_next & BYTE_MSB), nack_reg, drive_reg);
                end
            end
        end else begin
            case (func)
                CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: begin
                    cmd_next   = cmd_t'(func);
                    phase_next = '0;
                    shift_next = (func == CMD_WRITE) ? write_data : 8'h00;
                    if (func == CMD_READ) begin
                        nack_next = last_read;
                    end
                    div_next   = tpp_eff;
                    drive_next = enter_drive(cmd_t'(func), '0, |(shift_next & BYTE_MSB),
                                             nack_next, drive_reg);
                end
                default: begin
                    cmd_next = CMD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            shift_reg <= '0;
            div_reg   <= '0;
            drive_reg <= '{scl: 1'b1, sda: 1'b1, en: 1'b0};
            ack_reg   <= 1'b0;
            nack_reg  <= 1'b0;
            read_reg  <= '0;
        end else if (adv) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            div_reg   <= div_next;
            drive_reg <= drive_next;
            ack_reg   <= ack_next;
            nack_reg  <= nack_next;
            read_reg  <= read_next;
        end
    end

    assign res.ack       = ack_next;
    assign res.read_byte = read_next;
    assign res.done      = done;
    assign res.busy      = (cmd_next != CMD_IDLE);
    assign res.drive     = drive_next;

endmodule
`default_nettype wire
